[rtl/free_list_allocator_coalescing_top_assert.svh]
// Assertion macros used by the checker file
`ifndef FREE_LIST_ALLOCATOR_COALESCING_TOP_ASSERT_SVH
`define FREE_LIST_ALLOCATOR_COALESCING_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FLA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("fla assertion failed");

// Next-cycle implication, disabled during reset
`define FLA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("fla assertion failed");

// Next-cycle implication that also holds through reset
`define FLA_ASSERT_RST(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("fla reset assertion failed");

`endif

[rtl/fla_pkg.sv]
`default_nettype none
package fla_pkg;

    localparam int ARENA_BYTES       = 65536;
    localparam int MAX_SEGMENTS      = 32;
    localparam int MAX_LIVE          = 32;
    localparam int DATA_HEADER_BYTES = 16;
    localparam int NODE_HEADER_BYTES = 16;

    localparam int ADDR_W   = 16;
    localparam int TOT_W    = 17;
    localparam int PAD_W    = 13;
    localparam int NEED_W   = 18;
    localparam int LG_W     = 4;
    localparam int LG_MAX   = 12;
    localparam int SEG_AW   = $clog2(MAX_SEGMENTS);
    localparam int LIVE_AW  = $clog2(MAX_LIVE);
    localparam int SEG_CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int LIVE_CW  = $clog2(MAX_LIVE + 1);
    localparam int IDX_W    = (SEG_CW > LIVE_CW) ? SEG_CW : LIVE_CW;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [2:0] REG_FIT_MODE = 3'd0;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NOFIT   = 2'd1,
        STS_UNKNOWN = 2'd2,
        STS_FULL    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_EV,
        S_A_SLOT,
        S_F_RD,
        S_F_EV,
        S_P_RD,
        S_P_EV,
        S_MERGE,
        S_RM_RD,
        S_RM_WR,
        S_IN_RD,
        S_IN_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [TOT_W-1:0]  total;
    } t_seg;

    typedef struct packed {
        logic [ADDR_W-1:0] uaddr;
        logic [PAD_W-1:0]  pad;
        logic [ADDR_W-1:0] size;
    } t_live;

    // Smallest pad >= data header that aligns start + pad
    function automatic logic [PAD_W-1:0] pad_for(input logic [ADDR_W-1:0] s,
                                                 input logic [LG_W-1:0] lg);
        logic [LG_W-1:0] lg_c;
        logic [TOT_W-1:0] mask;
        logic [TOT_W-1:0] sum;
        logic [TOT_W-1:0] up;
        logic [TOT_W-1:0] pad;
        lg_c = (lg > LG_W'(LG_MAX)) ? LG_W'(LG_MAX) : lg;
        mask = (TOT_W'(1) << lg_c) - TOT_W'(1);
        sum  = {1'b0, s} + TOT_W'(DATA_HEADER_BYTES) + mask;
        up   = sum & ~mask;
        pad  = up - {1'b0, s};
        return pad[PAD_W-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/free_list_allocator_coalescing_top.sv]
// Free-list allocator with address-ordered segment table and coalescing.
// Input channel (i_s_*): one word per request, kind in tuser (0 allocate,
// 1 free). Output channel (o_m_*): one word per request, user address in
// tdata, status in tuser. Configuration: APB, register 0 bit 0 = fit mode.
// Segment table and live table sit in synchronous memories with one write
// port and one read port; each entry visited is read, then evaluated.
// Allocate: scan the segments (first fit stops at the hit, best fit scans
// all), pick a slot, then shift entries down when a segment is used up.
// Free: scan the valid live entries up to the match, skipping empty ones,
// then the segments up to the insert point, then shift entries on insert
// or on a merge with both neighbours.
// One request is in flight at a time; a new word is taken as soon as the
// previous result sits in the output register, even if not yet taken.
// Reset: the init state writes the whole arena as the single free segment,
// tready low meanwhile. A stalled output holds the word and the block
// waits in its final state before writing the next result.
`default_nettype none
module free_list_allocator_coalescing_top
    import fla_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,  // req_size[15:0], align_log2[19:16], user_address[35:20]
    input  wire logic        i_s_tuser,  // kind[0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,  // result_address[15:0]
    output logic [1:0]       o_m_tuser,  // status[1:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_state r_state, n_state;
    logic   r_fit;
    logic [SEG_CW-1:0] r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [SEG_CW-1:0] r_k, n_k;
    logic [ADDR_W-1:0] r_size, n_size;
    logic [LG_W-1:0]   r_lg, n_lg;
    logic [ADDR_W-1:0] r_ua, n_ua;
    logic              r_found, n_found;
    logic [SEG_AW-1:0] r_best_idx, n_best_idx;
    logic [TOT_W-1:0]  r_best_tot, n_best_tot;
    logic [PAD_W-1:0]  r_best_pad, n_best_pad;
    logic [ADDR_W-1:0] r_best_start, n_best_start;
    logic [LIVE_AW-1:0] r_slot, n_slot;
    logic [ADDR_W-1:0] r_bs, n_bs;
    logic [TOT_W-1:0]  r_bt, n_bt;
    t_seg              r_prev, n_prev;
    t_seg              r_next, n_next;
    logic              r_has_next, n_has_next;
    logic [MAX_LIVE-1:0] r_valid, n_valid;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    t_status           r_res_sts, n_res_sts;
    logic              r_ovalid, n_ovalid;
    logic [ADDR_W-1:0] r_oaddr, n_oaddr;
    t_status           r_osts, n_osts;

    // Segment memory
    t_seg              r_seg_mem [MAX_SEGMENTS];
    t_seg              r_seg_q;
    logic              seg_we;
    logic [SEG_AW-1:0] seg_waddr, seg_raddr;
    t_seg              seg_wdata;

    // Live-allocation memory
    t_live              r_live_mem [MAX_LIVE];
    t_live              r_live_q;
    logic               live_we;
    logic [LIVE_AW-1:0] live_raddr;
    t_live              live_wdata;

    logic              cfg_wr;
    logic              out_free;
    logic [PAD_W-1:0]  ev_pad;
    logic [NEED_W-1:0] ev_need, ev_tot, sl_need;
    logic              ev_fits;
    logic              have_slot;
    logic [LIVE_AW-1:0] free_slot;
    logic              mprev, mnext;
    logic [SEG_AW-1:0] pos;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == REG_FIT_MODE) ? {31'b0, r_fit} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit <= 1'b0;
        end else if (cfg_wr && (paddr[2] == REG_FIT_MODE[2])) begin
            r_fit <= pwdata[0];
        end
    end

    // Memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            r_seg_mem[seg_waddr] <= seg_wdata;
        end
        r_seg_q <= r_seg_mem[seg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (live_we) begin
            r_live_mem[free_slot] <= live_wdata;
        end
        r_live_q <= r_live_mem[live_raddr];
    end

    // Fit check on the segment just read
    always_comb begin
        ev_pad  = pad_for(r_seg_q.start, r_lg);
        ev_need = NEED_W'(r_size) + NEED_W'(ev_pad) + NEED_W'(DATA_HEADER_BYTES);
        ev_tot  = NEED_W'(r_seg_q.total);
        ev_fits = (ev_tot == ev_need) ||
                  ((ev_tot > ev_need) && ((ev_tot - ev_need) >= NEED_W'(NODE_HEADER_BYTES)));
        sl_need = NEED_W'(r_size) + NEED_W'(r_best_pad) + NEED_W'(DATA_HEADER_BYTES);
    end

    // Lowest free live slot
    always_comb begin
        have_slot = 1'b0;
        free_slot = '0;
        for (int i = MAX_LIVE - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                have_slot = 1'b1;
                free_slot = LIVE_AW'(i);
            end
        end
    end

    // Neighbor touch tests for a free
    assign pos   = r_idx[SEG_AW-1:0];
    assign mprev = (r_idx != '0) &&
                   ((NEED_W'(r_prev.start) + NEED_W'(r_prev.total)) == NEED_W'(r_bs));
    assign mnext = r_has_next && ((TOT_W'(r_bs) + r_bt) == TOT_W'(r_next.start));

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_oaddr;
    assign o_m_tuser  = r_osts;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_count  <= SEG_CW'(1);
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_valid  <= n_valid;
            r_ovalid <= n_ovalid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_k          <= n_k;
        r_size       <= n_size;
        r_lg         <= n_lg;
        r_ua         <= n_ua;
        r_found      <= n_found;
        r_best_idx   <= n_best_idx;
        r_best_tot   <= n_best_tot;
        r_best_pad   <= n_best_pad;
        r_best_start <= n_best_start;
        r_slot       <= n_slot;
        r_bs         <= n_bs;
        r_bt         <= n_bt;
        r_prev       <= n_prev;
        r_next       <= n_next;
        r_has_next   <= n_has_next;
        r_res_addr   <= n_res_addr;
        r_res_sts    <= n_res_sts;
        r_oaddr      <= n_oaddr;
        r_osts       <= n_osts;
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_k          = r_k;
        n_size       = r_size;
        n_lg         = r_lg;
        n_ua         = r_ua;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_tot   = r_best_tot;
        n_best_pad   = r_best_pad;
        n_best_start = r_best_start;
        n_slot       = r_slot;
        n_bs         = r_bs;
        n_bt         = r_bt;
        n_prev       = r_prev;
        n_next       = r_next;
        n_has_next   = r_has_next;
        n_valid      = r_valid;
        n_res_addr   = r_res_addr;
        n_res_sts    = r_res_sts;
        n_ovalid     = r_ovalid;
        n_oaddr      = r_oaddr;
        n_osts       = r_osts;
        seg_we       = 1'b0;
        seg_waddr    = '0;
        seg_wdata    = '0;
        seg_raddr    = '0;
        live_we      = 1'b0;
        live_raddr   = '0;
        live_wdata   = '0;

        // Drop the output word once taken
        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                seg_we    = 1'b1;
                seg_waddr = '0;
                seg_wdata = '{start: '0, total: TOT_W'(ARENA_BYTES)};
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_size     = i_s_tdata[15:0];
                    n_lg       = i_s_tdata[19:16];
                    n_ua       = i_s_tdata[35:20];
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_res_addr = '0;
                    n_state    = (i_s_tuser == KIND_ALLOC) ? S_A_RD : S_F_RD;
                end
            end
            S_A_RD: begin
                seg_raddr = r_idx[SEG_AW-1:0];
                if (r_idx >= IDX_W'(r_count)) begin
                    if (r_found) begin
                        n_state = S_A_SLOT;
                    end else begin
                        n_res_sts = STS_NOFIT;
                        n_state   = S_DONE;
                    end
                end else begin
                    n_state = S_A_EV;
                end
            end
            S_A_EV: begin
                n_state = S_A_RD;
                n_idx   = r_idx + IDX_W'(1);
                if (ev_fits && (!r_found || (r_fit && (r_seg_q.total < r_best_tot)))) begin
                    n_found      = 1'b1;
                    n_best_idx   = r_idx[SEG_AW-1:0];
                    n_best_tot   = r_seg_q.total;
                    n_best_pad   = ev_pad;
                    n_best_start = r_seg_q.start;
                end
                if (ev_fits && !r_fit) begin
                    n_state = S_A_SLOT;
                end
            end
            S_A_SLOT: begin
                if (!have_slot) begin
                    n_res_sts = STS_FULL;
                    n_state   = S_DONE;
                end else begin
                    n_slot              = free_slot;
                    n_valid[free_slot]  = 1'b1;
                    n_res_addr          = r_best_start + ADDR_W'(r_best_pad);
                    n_res_sts           = STS_OK;
                    if (NEED_W'(r_best_tot) == sl_need) begin
                        n_k     = SEG_CW'(r_best_idx);
                        n_state = S_RM_RD;
                    end else begin
                        seg_we          = 1'b1;
                        seg_waddr       = r_best_idx;
                        seg_wdata.start = r_best_start + sl_need[ADDR_W-1:0];
                        seg_wdata.total = r_best_tot - sl_need[TOT_W-1:0];
                        n_state         = S_DONE;
                    end
                end
            end
            S_F_RD: begin
                live_raddr = r_idx[LIVE_AW-1:0];
                if (r_idx >= IDX_W'(MAX_LIVE)) begin
                    n_res_sts = STS_UNKNOWN;
                    n_state   = S_DONE;
                end else if (!r_valid[r_idx[LIVE_AW-1:0]]) begin
                    n_idx = r_idx + IDX_W'(1);
                end else begin
                    n_state = S_F_EV;
                end
            end
            S_F_EV: begin
                if (r_live_q.uaddr == r_ua) begin
                    n_slot  = r_idx[LIVE_AW-1:0];
                    n_bs    = r_ua - ADDR_W'(DATA_HEADER_BYTES) - ADDR_W'(r_live_q.pad);
                    n_bt    = TOT_W'(r_live_q.pad) + TOT_W'(DATA_HEADER_BYTES) +
                              TOT_W'(r_live_q.size);
                    n_idx   = '0;
                    n_state = S_P_RD;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_F_RD;
                end
            end
            S_P_RD: begin
                seg_raddr = r_idx[SEG_AW-1:0];
                if (r_idx >= IDX_W'(r_count)) begin
                    n_has_next = 1'b0;
                    n_state    = S_MERGE;
                end else begin
                    n_state = S_P_EV;
                end
            end
            S_P_EV: begin
                if (r_seg_q.start <= r_bs) begin
                    n_prev  = r_seg_q;
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_P_RD;
                end else begin
                    n_next     = r_seg_q;
                    n_has_next = 1'b1;
                    n_state    = S_MERGE;
                end
            end
            S_MERGE: begin
                n_res_sts = STS_OK;
                n_state   = S_DONE;
                if (mprev && mnext) begin
                    seg_we          = 1'b1;
                    seg_waddr       = pos - SEG_AW'(1);
                    seg_wdata.start = r_prev.start;
                    seg_wdata.total = r_prev.total + r_bt + r_next.total;
                    n_valid[r_slot] = 1'b0;
                    n_k             = SEG_CW'(r_idx);
                    n_state         = S_RM_RD;
                end else if (mprev) begin
                    seg_we          = 1'b1;
                    seg_waddr       = pos - SEG_AW'(1);
                    seg_wdata.start = r_prev.start;
                    seg_wdata.total = r_prev.total + r_bt;
                    n_valid[r_slot] = 1'b0;
                end else if (mnext) begin
                    seg_we          = 1'b1;
                    seg_waddr       = pos;
                    seg_wdata.start = r_bs;
                    seg_wdata.total = r_next.total + r_bt;
                    n_valid[r_slot] = 1'b0;
                end else if (r_count >= SEG_CW'(MAX_SEGMENTS)) begin
                    n_res_sts = STS_FULL;
                end else begin
                    n_valid[r_slot] = 1'b0;
                    n_k             = r_count;
                    n_state         = S_IN_RD;
                end
            end
            S_RM_RD: begin
                // Shift the tail down by one entry
                seg_raddr = SEG_AW'(r_k + SEG_CW'(1));
                if ((r_k + SEG_CW'(1)) < r_count) begin
                    n_state = S_RM_WR;
                end else begin
                    n_count = r_count - SEG_CW'(1);
                    n_state = S_DONE;
                end
            end
            S_RM_WR: begin
                seg_we    = 1'b1;
                seg_waddr = r_k[SEG_AW-1:0];
                seg_wdata = r_seg_q;
                n_k       = r_k + SEG_CW'(1);
                n_state   = S_RM_RD;
            end
            S_IN_RD: begin
                // Shift the tail up by one entry, then place the span
                seg_raddr = SEG_AW'(r_k - SEG_CW'(1));
                if (r_k > SEG_CW'(r_idx)) begin
                    n_state = S_IN_WR;
                end else begin
                    seg_we          = 1'b1;
                    seg_waddr       = pos;
                    seg_wdata.start = r_bs;
                    seg_wdata.total = r_bt;
                    n_count         = r_count + SEG_CW'(1);
                    n_state         = S_DONE;
                end
            end
            S_IN_WR: begin
                seg_we    = 1'b1;
                seg_waddr = r_k[SEG_AW-1:0];
                seg_wdata = r_seg_q;
                n_k       = r_k - SEG_CW'(1);
                n_state   = S_IN_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oaddr  = r_res_addr;
                    n_osts   = r_res_sts;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        live_wdata.uaddr = r_best_start + ADDR_W'(r_best_pad);
        live_wdata.pad   = r_best_pad;
        live_wdata.size  = r_size;
        if ((r_state == S_A_SLOT) && have_slot) begin
            live_we = 1'b1;
        end
    end

endmodule
`default_nettype wire

[rtl/fla_chk.sv]
`default_nettype none
`include "free_list_allocator_coalescing_top_assert.svh"
module fla_chk
    import fla_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata,
    input wire logic [1:0]  o_m_tuser,
    input wire logic        pready
);

    // No result word right after reset
    `FLA_ASSERT_RST(a_rst_quiet, i_clk, !i_rst_n, !o_m_tvalid)

    // A failed request reports address zero
    `FLA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != STS_OK), o_m_tdata == 16'd0)

    // A stalled result word holds
    `FLA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // A taken request is followed by a busy cycle
    `FLA_ASSERT_NXT(a_one_inflight, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // Configuration port never waits
    `FLA_ASSERT_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind free_list_allocator_coalescing_top fla_chk u_fla_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .pready     (pready)
);
`default_nettype wire
